@@ sv/pfa_pkg.sv @@
// shared types and constants of the paging frame allocator
`default_nettype none
package pfa_pkg;
   localparam int MAX_FRAMES = 256;
   localparam int MAX_PROCS  = 64;
   localparam int MAX_PAGES  = 32;
   localparam int FRAME_W    = 8;
   localparam int PID_W      = 7;
   localparam int PIDX_W     = 6;
   localparam int PAGE_W     = 5;
   localparam int PCNT_W     = 6;
   localparam int CNT_W      = 9;
   localparam int SIZE_W     = 16;
   localparam int STAT_W     = 4;
   localparam int DIV_W      = 17;
   localparam int DCNT_W     = 5;

   localparam logic [1:0] OP_DEFINE = 2'd0;
   localparam logic [1:0] OP_ALLOC  = 2'd1;
   localparam logic [1:0] OP_FREE   = 2'd2;
   localparam logic [1:0] OP_READ   = 2'd3;

   localparam logic [STAT_W-1:0] ST_PLACED   = 4'd0;
   localparam logic [STAT_W-1:0] ST_DONE     = 4'd1;
   localparam logic [STAT_W-1:0] ST_NOFRAME  = 4'd2;
   localparam logic [STAT_W-1:0] ST_UNKNOWN  = 4'd3;
   localparam logic [STAT_W-1:0] ST_DEFINED  = 4'd4;
   localparam logic [STAT_W-1:0] ST_TRUNC    = 4'd5;
   localparam logic [STAT_W-1:0] ST_FREED    = 4'd6;
   localparam logic [STAT_W-1:0] ST_READ     = 4'd7;
   localparam logic [STAT_W-1:0] ST_BADINDEX = 4'd8;
   localparam logic [STAT_W-1:0] ST_BADSIZE  = 4'd9;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_DIV, S_READ, S_ALLOC_LOAD, S_ALLOC_CHK, S_ALLOC_SCAN,
      S_FREE_SCAN, S_EMIT
   } state_type;

   typedef enum logic [2:0] {
      EM_PLACED, EM_DONE, EM_NOFRAME, EM_UNKNOWN, EM_DEFINE, EM_FREED, EM_READ,
      EM_BADSIZE
   } emit_type;

   typedef struct packed {
      logic     load;
      logic     div_start;
      logic     div_step;
      logic     alloc_init;
      logic     load_pages;
      logic     scan_step;
      logic     free_init;
      logic     free_step;
      logic     emit;
      emit_type emit_code;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       pid_ok;
      logic       defined;
      logic       pgsize_zero;
      logic       out_free;
      logic       div_done;
      logic       pages_done;
      logic       scan_end;
      logic       scan_free;
      logic       free_done;
   } status_type;
endpackage
`default_nettype wire

@@ sv/pfa_ctrl.sv @@
// controller state machine of the frame allocator
`default_nettype none
module pfa_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  pfa_pkg::status_type stat,
   output pfa_pkg::cmd_type    cmd
);
   import pfa_pkg::*;

   state_type state_ff, state_in;
   emit_type  code_ff, code_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         code_ff  <= EM_UNKNOWN;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      code_in   = code_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.op == OP_READ) begin
               state_in = S_READ;
            end else if (!stat.pid_ok || (stat.op != OP_DEFINE && !stat.defined)) begin
               code_in  = EM_UNKNOWN;
               state_in = S_EMIT;
            end else if (stat.op == OP_DEFINE) begin
               if (stat.pgsize_zero) begin
                  code_in  = EM_BADSIZE;
                  state_in = S_EMIT;
               end else begin
                  cmd.div_start = 1'b1;
                  state_in      = S_DIV;
               end
            end else if (stat.op == OP_ALLOC) begin
               cmd.alloc_init = 1'b1;
               state_in       = S_ALLOC_LOAD;
            end else begin
               cmd.free_init = 1'b1;
               state_in      = S_FREE_SCAN;
            end
         end
         S_DIV: begin
            if (stat.div_done) begin
               code_in  = EM_DEFINE;
               state_in = S_EMIT;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_READ: begin
            code_in  = EM_READ;
            state_in = S_EMIT;
         end
         S_ALLOC_LOAD: begin
            cmd.load_pages = 1'b1;
            state_in       = S_ALLOC_CHK;
         end
         S_ALLOC_CHK: begin
            if (stat.pages_done) begin
               code_in  = EM_DONE;
               state_in = S_EMIT;
            end else begin
               state_in = S_ALLOC_SCAN;
            end
         end
         S_ALLOC_SCAN: begin
            if (stat.scan_end) begin
               code_in  = EM_NOFRAME;
               state_in = S_EMIT;
            end else if (!stat.scan_free) begin
               cmd.scan_step = 1'b1;
            end else if (stat.out_free) begin
               // place one page and show its beat
               cmd.emit      = 1'b1;
               cmd.emit_code = EM_PLACED;
               state_in      = S_ALLOC_CHK;
            end
         end
         S_FREE_SCAN: begin
            if (stat.free_done) begin
               code_in  = EM_FREED;
               state_in = S_EMIT;
            end else begin
               cmd.free_step = 1'b1;
            end
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_code = code_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule
`default_nettype wire

@@ sv/pfa_dp.sv @@
// datapath: frame table, process table, divider and result register
`default_nettype none
module pfa_dp (
   input  wire                           clock,
   input  wire                           reset,
   input  wire  [pfa_pkg::CNT_W-1:0]     frames_active,
   input  wire  [55:0]                   req_data,
   input  pfa_pkg::cmd_type              cmd,
   output pfa_pkg::status_type           stat,
   input  wire                           rsp_ready,
   output logic                          rsp_valid,
   output logic [39:0]                   rsp_data,
   output logic                          rsp_last
);
   import pfa_pkg::*;

   // latched item
   logic [1:0]        op_ff;
   logic [PID_W-1:0]  pid_ff;
   logic [SIZE_W-1:0] psize_ff, pgsize_ff;
   logic [FRAME_W-1:0] fidx_ff;

   // frame table: owner and page per frame, valid bit means owned
   logic [PID_W+PAGE_W-1:0] frame_mem [MAX_FRAMES];
   logic [MAX_FRAMES-1:0]   fvalid_ff;
   logic [PID_W+PAGE_W-1:0] frd_ff;

   // process table
   logic [PCNT_W-1:0] pages_mem [MAX_PROCS];
   logic [MAX_PROCS-1:0] defined_ff;
   logic [PCNT_W-1:0] prd_ff;

   logic [CNT_W-1:0]   scan_ff;
   logic [FRAME_W-1:0] scan_d_ff;
   logic               pend_ff;
   logic [PCNT_W-1:0]  page_ff, pages_ff;
   logic [CNT_W-1:0]   freed_ff;
   logic [DIV_W-1:0]   rem_ff, dvd_ff;
   logic [DCNT_W-1:0]  dcnt_ff;

   logic               ovalid_ff;
   logic [STAT_W-1:0]  ostat_ff;
   logic [FRAME_W-1:0] oframe_ff;
   logic [PAGE_W-1:0]  opage_ff;
   logic [PID_W-1:0]   oowner_ff;
   logic [CNT_W-1:0]   ocount_ff;
   logic               olast_ff;

   logic [PIDX_W-1:0]  pidx;
   logic [FRAME_W-1:0] faddr;
   logic [DIV_W-1:0]   shifted;
   logic               qbit;
   logic               trunc;
   logic [PCNT_W-1:0]  def_pages;
   logic               hit;
   logic               out_free;

   assign pidx     = PIDX_W'(pid_ff - PID_W'(1));
   assign faddr    = (op_ff == OP_FREE) ? scan_ff[FRAME_W-1:0] : fidx_ff;
   assign shifted  = {rem_ff[DIV_W-2:0], dvd_ff[DIV_W-1]};
   assign qbit     = shifted >= {1'b0, pgsize_ff};
   assign trunc    = dvd_ff > DIV_W'(MAX_PAGES);
   assign def_pages = trunc ? PCNT_W'(MAX_PAGES) : dvd_ff[PCNT_W-1:0];
   assign hit      = pend_ff && fvalid_ff[scan_d_ff] &&
                     (frd_ff[PID_W+PAGE_W-1:PAGE_W] == pid_ff);
   assign out_free = !ovalid_ff || rsp_ready;

   always_comb begin
      stat.op          = op_ff;
      stat.pid_ok      = (pid_ff != '0) && (pid_ff <= PID_W'(MAX_PROCS));
      stat.defined     = defined_ff[pidx];
      stat.pgsize_zero = (pgsize_ff == '0);
      stat.out_free    = out_free;
      stat.div_done    = (dcnt_ff == '0);
      stat.pages_done  = (page_ff == pages_ff);
      stat.scan_end    = (scan_ff >= frames_active);
      stat.scan_free   = !fvalid_ff[scan_ff[FRAME_W-1:0]];
      stat.free_done   = (scan_ff >= frames_active) && !pend_ff;
   end

   // memories
   always_ff @(posedge clock) begin
      frd_ff <= frame_mem[faddr];
      prd_ff <= pages_mem[pidx];
      if (cmd.emit && cmd.emit_code == EM_PLACED) begin
         frame_mem[scan_ff[FRAME_W-1:0]] <= {pid_ff, page_ff[PAGE_W-1:0]};
      end
      if (cmd.emit && cmd.emit_code == EM_DEFINE) begin
         pages_mem[pidx] <= def_pages;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_data[1:0];
         pid_ff    <= req_data[8:2];
         psize_ff  <= req_data[24:9];
         pgsize_ff <= req_data[40:25];
         fidx_ff   <= req_data[48:41];
      end
      if (cmd.div_start) begin
         rem_ff  <= '0;
         dvd_ff  <= DIV_W'(psize_ff) + DIV_W'(pgsize_ff) - DIV_W'(1);
         dcnt_ff <= DCNT_W'(DIV_W);
      end else if (cmd.div_step) begin
         rem_ff  <= qbit ? shifted - {1'b0, pgsize_ff} : shifted;
         dvd_ff  <= {dvd_ff[DIV_W-2:0], qbit};
         dcnt_ff <= dcnt_ff - DCNT_W'(1);
      end
      if (cmd.alloc_init) begin
         scan_ff <= '0;
         page_ff <= '0;
      end else if (cmd.free_init) begin
         scan_ff  <= '0;
         freed_ff <= '0;
         pend_ff  <= 1'b0;
      end else if (cmd.scan_step) begin
         scan_ff <= scan_ff + CNT_W'(1);
      end else if (cmd.emit && cmd.emit_code == EM_PLACED) begin
         scan_ff <= scan_ff + CNT_W'(1);
         page_ff <= page_ff + PCNT_W'(1);
      end else if (cmd.free_step) begin
         // read issued at scan, compared in the next cycle
         scan_d_ff <= scan_ff[FRAME_W-1:0];
         pend_ff   <= (scan_ff < frames_active);
         if (scan_ff < frames_active) begin
            scan_ff <= scan_ff + CNT_W'(1);
         end
         if (hit) begin
            freed_ff <= freed_ff + CNT_W'(1);
         end
      end
      if (cmd.load_pages) begin
         pages_ff <= prd_ff;
      end
      if (cmd.emit) begin
         ostat_ff  <= ST_UNKNOWN;
         oframe_ff <= '0;
         opage_ff  <= '0;
         oowner_ff <= '0;
         ocount_ff <= '0;
         olast_ff  <= 1'b1;
         case (cmd.emit_code)
            EM_PLACED: begin
               ostat_ff  <= ST_PLACED;
               oframe_ff <= scan_ff[FRAME_W-1:0];
               opage_ff  <= page_ff[PAGE_W-1:0];
               olast_ff  <= 1'b0;
            end
            EM_DONE: begin
               ostat_ff  <= ST_DONE;
               ocount_ff <= CNT_W'(pages_ff);
            end
            EM_NOFRAME: begin
               ostat_ff  <= ST_NOFRAME;
               opage_ff  <= page_ff[PAGE_W-1:0];
               ocount_ff <= CNT_W'(page_ff);
            end
            EM_DEFINE: begin
               ostat_ff  <= trunc ? ST_TRUNC : ST_DEFINED;
               ocount_ff <= CNT_W'(def_pages);
            end
            EM_FREED: begin
               ostat_ff  <= ST_FREED;
               ocount_ff <= freed_ff;
            end
            EM_READ: begin
               if (CNT_W'(fidx_ff) >= frames_active) begin
                  ostat_ff <= ST_BADINDEX;
               end else begin
                  ostat_ff  <= ST_READ;
                  oframe_ff <= fidx_ff;
                  if (fvalid_ff[fidx_ff]) begin
                     opage_ff  <= frd_ff[PAGE_W-1:0];
                     oowner_ff <= frd_ff[PID_W+PAGE_W-1:PAGE_W];
                  end
               end
            end
            EM_BADSIZE: ostat_ff <= ST_BADSIZE;
            default:    ostat_ff <= ST_UNKNOWN;
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         fvalid_ff  <= '0;
         defined_ff <= '0;
         ovalid_ff  <= 1'b0;
      end else begin
         if (cmd.emit && cmd.emit_code == EM_PLACED) begin
            fvalid_ff[scan_ff[FRAME_W-1:0]] <= 1'b1;
         end else if (cmd.free_step && hit) begin
            fvalid_ff[scan_d_ff] <= 1'b0;
         end
         if (cmd.emit && cmd.emit_code == EM_DEFINE) begin
            defined_ff[pidx] <= 1'b1;
         end
         if (cmd.emit) begin
            ovalid_ff <= 1'b1;
         end else if (rsp_ready) begin
            ovalid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = ovalid_ff;
   assign rsp_last  = olast_ff;
   assign rsp_data  = {7'd0, ocount_ff, oowner_ff, opage_ff, oframe_ff, ostat_ff};
endmodule
`default_nettype wire

@@ sv/paging_frame_allocator_top.sv @@
// paging frame allocator: one item in flight, from the input beat to its last result beat
// free scans every active frame, allocate scans for a free frame per page and passes
// over used frames; the frame scan (one frame per cycle) and the 17-step divider set the
// rate; each held result beat stalls the scan
// next input beat taken in the cycle after the final beat enters the output register
// reset empties every frame, undefines every process, frame_count = 256
`default_nettype none
module paging_frame_allocator_top (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [55:0] req_tdata,   // operation, process_id, process_size_kb,
                                    // page_size_kb, frame_index, zero pad
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata,   // status, frame, page, owner, count, zero pad
   output logic        rsp_tlast,
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [2:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import pfa_pkg::*;

   logic [CNT_W-1:0] fcount_ff;
   logic [CNT_W-1:0] frames_active;
   cmd_type          cmd;
   status_type       stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         fcount_ff <= CNT_W'(MAX_FRAMES);
      end else if (csr_psel && csr_penable && csr_pwrite && !csr_paddr[2]) begin
         fcount_ff <= csr_pwdata[CNT_W-1:0];
      end
   end

   assign frames_active = (fcount_ff < CNT_W'(MAX_FRAMES)) ? fcount_ff : CNT_W'(MAX_FRAMES);
   assign csr_pready    = 1'b1;
   assign csr_prdata    = csr_paddr[2] ? 32'd0 : {23'd0, fcount_ff};

   pfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pfa_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .frames_active (frames_active),
      .req_data      (req_tdata),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_ready     (rsp_tready),
      .rsp_valid     (rsp_tvalid),
      .rsp_data      (rsp_tdata),
      .rsp_last      (rsp_tlast)
   );
endmodule
`default_nettype wire

@@ sv/pfa_checker.sv @@
// port-level checks of the frame allocator, bound to the top level
`default_nettype none
module pfa_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [39:0] rsp_tdata,
   input wire        rsp_tlast
);
   import pfa_pkg::*;

   // one item at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken twice in a row");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat dropped or changed");

   // only placed beats leave a run open
   a_open_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[3:0] == ST_PLACED &&
      rsp_tdata[32:17] == 16'd0)
      else $error("non-final beat that is not a placement");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[3:0] <= ST_BADSIZE)
      else $error("status code out of range");
endmodule

bind paging_frame_allocator_top pfa_checker u_pfa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire

@@ tb/tb.sv @@
// self-checking testbench of the paging frame allocator top level
`timescale 1ns / 1ps
module tb;
   import pfa_pkg::*;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [FRAME_W-1:0] frame;
      logic [PAGE_W-1:0]  page;
      logic [PID_W-1:0]   owner;
      logic [CNT_W-1:0]   count;
      logic               last;
   } alloc_result_t;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   wire         req_tready;
   logic [55:0] req_tdata;   // operation, process_id, process_size_kb,
                             // page_size_kb, frame_index, zero pad
   wire         rsp_tvalid;
   logic        rsp_tready;
   wire  [39:0] rsp_tdata;   // status, frame, page, owner, count, zero pad
   wire         rsp_tlast;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   wire  [31:0] csr_prdata;
   wire         csr_pready;

   paging_frame_allocator_top u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // mirror of the allocator state
   logic [PID_W-1:0]  mdl_owner [MAX_FRAMES];
   logic [PAGE_W-1:0] mdl_page  [MAX_FRAMES];
   logic [PCNT_W-1:0] mdl_pages [MAX_PROCS];
   logic              mdl_defd  [MAX_PROCS];
   int unsigned       mdl_frame_count;

   alloc_result_t expected_results[$];
   int  error_count;
   int  items_sent;
   int  results_seen;
   bit  no_idle;
   int  rsp_stall;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("paging_frame_allocator_top test failed");
      $finish;
   end

   function automatic alloc_result_t mk(logic [STAT_W-1:0] st, int fr, int pg,
                                        int ow, int cnt, bit lst);
      alloc_result_t r;
      r.status = st;
      r.frame  = fr[FRAME_W-1:0];
      r.page   = pg[PAGE_W-1:0];
      r.owner  = ow[PID_W-1:0];
      r.count  = cnt[CNT_W-1:0];
      r.last   = lst;
      return r;
   endfunction

   function automatic void add_expected(alloc_result_t r);
      expected_results = {expected_results, r};
   endfunction

   // computes the results of one accepted item and updates the mirror
   task automatic predict_allocator(logic [1:0] op, logic [6:0] pid,
                                    logic [15:0] psize, logic [15:0] pgsize,
                                    logic [7:0] fidx);
      int unsigned nf;
      int unsigned pages;
      int unsigned freed;
      int j;
      int i;
      bit found;
      nf = (mdl_frame_count < MAX_FRAMES) ? mdl_frame_count : MAX_FRAMES;
      if (op == OP_READ) begin
         if (fidx >= nf)
            add_expected(mk(ST_BADINDEX, 0, 0, 0, 0, 1));
         else
            add_expected(mk(ST_READ, fidx, mdl_page[fidx], mdl_owner[fidx], 0, 1));
         return;
      end
      if (pid < 1 || pid > MAX_PROCS) begin
         add_expected(mk(ST_UNKNOWN, 0, 0, 0, 0, 1));
         return;
      end
      if (op == OP_DEFINE) begin
         if (pgsize == 0) begin
            add_expected(mk(ST_BADSIZE, 0, 0, 0, 0, 1));
            return;
         end
         pages = (int'(psize) + int'(pgsize) - 1) / int'(pgsize);
         mdl_defd[pid-1] = 1'b1;
         if (pages > MAX_PAGES) begin
            mdl_pages[pid-1] = PCNT_W'(MAX_PAGES);
            add_expected(mk(ST_TRUNC, 0, 0, 0, MAX_PAGES, 1));
         end else begin
            mdl_pages[pid-1] = pages[PCNT_W-1:0];
            add_expected(mk(ST_DEFINED, 0, 0, 0, pages, 1));
         end
         return;
      end
      if (!mdl_defd[pid-1]) begin
         add_expected(mk(ST_UNKNOWN, 0, 0, 0, 0, 1));
         return;
      end
      if (op == OP_ALLOC) begin
         pages = mdl_pages[pid-1];
         for (i = 0; i < pages; i++) begin
            found = 0;
            for (j = 0; j < nf; j++) begin
               if (mdl_owner[j] == 0) begin
                  found = 1;
                  break;
               end
            end
            if (!found) begin
               add_expected(mk(ST_NOFRAME, 0, i, 0, i, 1));
               return;
            end
            mdl_owner[j] = pid;
            mdl_page[j]  = i[PAGE_W-1:0];
            add_expected(mk(ST_PLACED, j, i, 0, 0, 0));
         end
         add_expected(mk(ST_DONE, 0, 0, 0, pages, 1));
         return;
      end
      freed = 0;
      for (j = 0; j < nf; j++) begin
         if (mdl_owner[j] == pid) begin
            mdl_owner[j] = 0;
            mdl_page[j]  = 0;
            freed++;
         end
      end
      add_expected(mk(ST_FREED, 0, 0, 0, freed, 1));
   endtask

   // sends one request beat; valid stays high between back-to-back beats
   task automatic send_request(logic [1:0] op, logic [6:0] pid, logic [15:0] psize,
                               logic [15:0] pgsize, logic [7:0] fidx);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, fidx, pgsize, psize, pid, op};
      // ready is sampled as it stands at the accepting edge
      @(posedge clock iff req_tready);
      predict_allocator(op, pid, psize, pgsize, fidx);
      items_sent++;
   endtask

   task automatic drain_results();
      @(posedge clock);
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_frame_count(int unsigned value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= 3'd0;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      mdl_frame_count = value & 9'h1FF;
   endtask

   always @(posedge clock) begin
      alloc_result_t got;
      alloc_result_t exp_r;
      int            draw;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall  <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tdata[3:0];
            got.frame  = rsp_tdata[11:4];
            got.page   = rsp_tdata[16:12];
            got.owner  = rsp_tdata[23:17];
            got.count  = rsp_tdata[32:24];
            got.last   = rsp_tlast;
            results_seen++;
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result beat %h", $realtime, got);
               error_count++;
            end else begin
               exp_r = expected_results.pop_front();
               if (got.status !== exp_r.status) begin
                  $display("%0t: status exp %0d got %0d", $realtime, exp_r.status,
                           got.status);
                  error_count++;
               end
               if (got.frame !== exp_r.frame) begin
                  $display("%0t: frame exp %0d got %0d", $realtime, exp_r.frame,
                           got.frame);
                  error_count++;
               end
               if (got.page !== exp_r.page) begin
                  $display("%0t: page exp %0d got %0d", $realtime, exp_r.page,
                           got.page);
                  error_count++;
               end
               if (got.owner !== exp_r.owner) begin
                  $display("%0t: owner exp %0d got %0d", $realtime, exp_r.owner,
                           got.owner);
                  error_count++;
               end
               if (got.count !== exp_r.count) begin
                  $display("%0t: count exp %0d got %0d", $realtime, exp_r.count,
                           got.count);
                  error_count++;
               end
               if (got.last !== exp_r.last) begin
                  $display("%0t: last exp %0d got %0d", $realtime, exp_r.last,
                           got.last);
                  error_count++;
               end
            end
            draw = no_idle ? 0 : $urandom_range(0, 13);
            if (draw == 0) begin
               rsp_tready <= 1'b1;
               rsp_stall  <= 0;
            end else begin
               rsp_tready <= 1'b0;
               rsp_stall  <= draw - 1;
            end
         end else if (rsp_stall > 0) begin
            rsp_stall  <= rsp_stall - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_random_request(int unsigned fc);
      logic [1:0]  op;
      logic [6:0]  pid;
      logic [15:0] psize;
      logic [15:0] pgsize;
      logic [7:0]  fidx;
      int unsigned sel;
      sel = $urandom_range(0, 99);
      op = (sel < 30) ? OP_DEFINE : (sel < 62) ? OP_ALLOC : (sel < 80) ? OP_FREE : OP_READ;
      pid = ($urandom_range(0, 99) < 85) ? 7'($urandom_range(1, 8))
                                         : 7'($urandom_range(0, 127));
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
         psize  = 16'($urandom_range(0, 200));
         pgsize = 16'($urandom_range(1, 64));
      end else if (sel < 80) begin
         psize  = 16'($urandom);
         pgsize = 16'd0;
      end else begin
         psize  = 16'($urandom);
         pgsize = 16'($urandom);
      end
      if ($urandom_range(0, 99) < 75 && fc > 1)
         fidx = 8'($urandom_range(0, (fc > 256 ? 256 : fc) - 1));
      else
         fidx = 8'($urandom);
      send_request(op, pid, psize, pgsize, fidx);
   endtask

   task automatic test_directed();
      send_request(OP_READ,   0,   0,     0,     0);
      send_request(OP_READ,   0,   0,     0,     255);
      send_request(OP_DEFINE, 0,   10,    2,     0);
      send_request(OP_DEFINE, 65,  10,    2,     0);
      send_request(OP_DEFINE, 127, 16'hFFFF, 16'hFFFF, 0);
      send_request(OP_DEFINE, 1,   100,   0,     0);
      send_request(OP_DEFINE, 1,   0,     4,     0);
      send_request(OP_ALLOC,  1,   0,     0,     0);
      send_request(OP_ALLOC,  2,   0,     0,     0);
      send_request(OP_FREE,   2,   0,     0,     0);
      send_request(OP_FREE,   0,   0,     0,     0);
      send_request(OP_DEFINE, 2,   16'hFFFF, 1,  0);
      send_request(OP_DEFINE, 64,  10,    4,     0);
      send_request(OP_ALLOC,  64,  0,     0,     0);
      send_request(OP_ALLOC,  2,   0,     0,     0);
      send_request(OP_READ,   0,   0,     0,     3);
      send_request(OP_ALLOC,  64,  0,     0,     0);
      // redefinition keeps the frames already owned
      send_request(OP_DEFINE, 64,  16'hFFFF, 16'hFFFF, 0);
      send_request(OP_FREE,   64,  0,     0,     0);
      send_request(OP_FREE,   2,   0,     0,     0);
      drain_results();
      write_frame_count(1);
      send_request(OP_DEFINE, 4,   5,     1,     0);
      send_request(OP_ALLOC,  4,   0,     0,     0);
      send_request(OP_READ,   0,   0,     0,     1);
      send_request(OP_READ,   0,   0,     0,     0);
      drain_results();
      // frame 0 stays owned while the count is 1 and is freed at the full count
      write_frame_count(256);
      send_request(OP_FREE,   4,   0,     0,     0);
      drain_results();
   endtask

   task automatic test_random_phase(int unsigned fc, int n, bit quiet);
      write_frame_count(fc);
      no_idle = quiet;
      repeat (n) send_random_request(fc);
      drain_results();
      no_idle = 0;
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      error_count = 0;
      items_sent  = 0;
      results_seen = 0;
      no_idle     = 0;
      mdl_frame_count = 256;
      foreach (mdl_owner[k]) begin
         mdl_owner[k] = '0;
         mdl_page[k]  = '0;
      end
      foreach (mdl_pages[k]) begin
         mdl_pages[k] = '0;
         mdl_defd[k]  = 1'b0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_phase(16, 50, 0);
      test_random_phase(255, 30, 1);
      test_random_phase(40, 50, 0);
      test_random_phase(256, 25, 0);
      drain_results();
      repeat (20) @(posedge clock);
      $display("covered %0d requests and %0d result beats: define, allocate, free, read,",
               items_sent, results_seen);
      $display("bad ids and sizes, truncation, frame exhaustion, frame counts 1 to 256");
      if (error_count == 0 && expected_results.size() == 0)
         $display("paging_frame_allocator_top test passed");
      else
         $display("paging_frame_allocator_top test failed");
      $finish;
   end
endmodule
